### src/hsl2rgb_pkg.sv
// Shared widths and defaults for the HSL to RGB converter.
`default_nettype none
package hsl2rgb_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IN_FRAC       = 16;
	localparam int HUE_W         = 16;
	localparam int SL_W          = 17;
	localparam int RGB_W         = 8;
	localparam logic [SL_W-1:0] SL_ONE = SL_W'(1) << IN_FRAC;
endpackage
`default_nettype wire

### src/hsl2rgb_front.sv
// Input rescaling, hue offsets and the q / p computation (stages 1 to 3).
`default_nettype none
module hsl2rgb_front #(
	parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [hsl2rgb_pkg::HUE_W-1:0] hue,
	input  wire logic [hsl2rgb_pkg::SL_W-1:0]  saturation,
	input  wire logic [hsl2rgb_pkg::SL_W-1:0]  lightness,
	output logic      [FRAC_BITS-1:0]          tr_s2,
	output logic      [FRAC_BITS-1:0]          tg_s2,
	output logic      [FRAC_BITS-1:0]          tb_s2,
	output logic      [FRAC_BITS:0]            p_s3,
	output logic      [FRAC_BITS:0]            q_s3,
	output logic      [FRAC_BITS:0]            span_s3
);
	localparam int F   = FRAC_BITS;
	localparam int SLX = hsl2rgb_pkg::SL_W + F;
	localparam int HX  = hsl2rgb_pkg::HUE_W + F;
	localparam logic [F-1:0] THIRD     = F'((1 << F) / 3);
	localparam logic [F-1:0] TWO_THIRD = F'((1 << F) - (1 << F) / 3);
	localparam logic [F+1:0] ONE_2     = (F+2)'(1) << F;
	localparam logic [F+2:0] ONE_3     = (F+3)'(1) << F;

	logic [hsl2rgb_pkg::SL_W-1:0] s_c, l_c;
	logic [SLX-1:0] s_x, l_x;
	logic [HX-1:0]  h_x;
	logic [F-1:0]   h_i;

	logic [F-1:0] tr_s1, tg_s1, tb_s1;
	logic [F:0]   s_s1, l_s1;

	logic [F+1:0]    m;
	logic            low_s2;
	logic [F:0]      l_s2, s_s2;
	logic [2*F+2:0]  prod_s2;

	logic [F+2:0] sh, q_raw, l2, pd;
	logic [F:0]   q_c, p_c;

	always_comb begin
		s_c = (saturation > hsl2rgb_pkg::SL_ONE) ? hsl2rgb_pkg::SL_ONE : saturation;
		l_c = (lightness > hsl2rgb_pkg::SL_ONE) ? hsl2rgb_pkg::SL_ONE : lightness;
		s_x = (SLX'(s_c) << F) >> hsl2rgb_pkg::IN_FRAC;
		l_x = (SLX'(l_c) << F) >> hsl2rgb_pkg::IN_FRAC;
		h_x = (HX'(hue) << F) >> hsl2rgb_pkg::IN_FRAC;
		h_i = h_x[F-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tg_s1 <= h_i;
			tr_s1 <= h_i + THIRD;
			tb_s1 <= h_i + TWO_THIRD;
			s_s1  <= s_x[F:0];
			l_s1  <= l_x[F:0];
		end
	end

	always_comb begin
		m = (l_s1[F:F-1] == 2'b00) ? (ONE_2 + (F+2)'(s_s1)) : (F+2)'(s_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tr_s2   <= tr_s1;
			tg_s2   <= tg_s1;
			tb_s2   <= tb_s1;
			low_s2  <= (l_s1[F:F-1] == 2'b00);
			l_s2    <= l_s1;
			s_s2    <= s_s1;
			prod_s2 <= (2*F+3)'(l_s1) * (2*F+3)'(m);
		end
	end

	always_comb begin
		sh    = prod_s2[2*F+2:F];
		q_raw = low_s2 ? sh : ((F+3)'(l_s2) + (F+3)'(s_s2) - sh);
		q_c   = (q_raw > ONE_3) ? ONE_3[F:0] : q_raw[F:0];
		l2    = (F+3)'(l_s2) << 1;
		pd    = l2 - (F+3)'(q_c);
		if (l2 < (F+3)'(q_c)) begin
			p_c = '0;
		end else if (pd > (F+3)'(q_c)) begin
			p_c = q_c;
		end else begin
			p_c = pd[F:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3    <= q_c;
			p_s3    <= p_c;
			span_s3 <= q_c - p_c;
		end
	end
endmodule
`default_nettype wire

### src/hsl2rgb_chan.sv
// One colour channel: hue segment, piecewise-linear value and byte scaling (stages 3 to 5).
`default_nettype none
module hsl2rgb_chan #(
	parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [FRAC_BITS-1:0]          t_s2,
	input  wire logic [FRAC_BITS:0]            p_s3,
	input  wire logic [FRAC_BITS:0]            q_s3,
	input  wire logic [FRAC_BITS:0]            span_s3,
	output logic      [hsl2rgb_pkg::RGB_W-1:0] chan_s5
);
	localparam int F = FRAC_BITS;
	localparam logic [F+2:0] ONE_3  = (F+3)'(1) << F;
	localparam logic [F+2:0] FOUR_3 = (F+3)'(4) << F;
	localparam logic [F+1:0] TWO_2  = (F+2)'(2) << F;

	typedef enum logic [1:0] {SEG_RISE, SEG_HOLD, SEG_FALL, SEG_BASE} seg_t;

	logic [F+2:0] t6;
	logic [F+1:0] t3;
	seg_t         seg_c, seg_s3;
	logic [F:0]   op_c, op_s3;

	logic [2*F+1:0] prod;
	logic [F+1:0]   sh;
	logic [F:0]     v_c, v_s4;

	logic [F+8:0] v255;
	logic [8:0]   b9;

	always_comb begin
		t6 = ((F+3)'(t_s2) << 2) + ((F+3)'(t_s2) << 1);
		t3 = ((F+2)'(t_s2) << 1) + (F+2)'(t_s2);
		if (t6 < ONE_3) begin
			seg_c = SEG_RISE;
			op_c  = t6[F:0];
		end else if (!t_s2[F-1]) begin
			seg_c = SEG_HOLD;
			op_c  = '0;
		end else if (t3 < TWO_2) begin
			seg_c = SEG_FALL;
			op_c  = (F+1)'(FOUR_3 - t6);
		end else begin
			seg_c = SEG_BASE;
			op_c  = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s3 <= seg_c;
			op_s3  <= op_c;
		end
	end

	always_comb begin
		prod = (2*F+2)'(span_s3) * (2*F+2)'(op_s3);
		sh   = prod[2*F+1:F];
		case (seg_s3)
			SEG_RISE, SEG_FALL: v_c = (F+1)'((F+2)'(p_s3) + sh);
			SEG_HOLD:           v_c = q_s3;
			SEG_BASE:           v_c = p_s3;
			default:            v_c = p_s3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4 <= v_c;
		end
	end

	always_comb begin
		v255 = ((F+9)'(v_s4) << 8) - (F+9)'(v_s4);
		b9   = v255[F+8:F];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chan_s5 <= b9[8] ? '1 : b9[7:0];
		end
	end
endmodule
`default_nettype wire

### src/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB converter: pipeline control and the three channels.
//
// Input channel: hue (Q0.16 turn), saturation and lightness (Q1.16, values above
// 1.0 clamp to 1.0) with in_valid / in_ready. Output channel: red, green, blue
// bytes with out_valid / out_ready, one result per item, in order.
// The pipeline has five register stages: rescale and hue offsets, the q
// multiply, q / p and hue segment, the three channel multiplies, byte scaling.
// Throughput is one item per cycle while out_ready does not hold the pipeline;
// each stage multiplier is combinational between its stage registers.
// The last stage is the output register. When out_ready is low with a result
// waiting, the whole pipeline holds and in_ready drops; no item is lost or
// repeated, and empty stage slots are held in place until the stall clears.
// Reset (arst_n low) clears all valid bits at once; the data path needs none.
`default_nettype none
module hsl_to_rgb_converter #(
	parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [hsl2rgb_pkg::HUE_W-1:0] hue,
	input  wire logic [hsl2rgb_pkg::SL_W-1:0]  saturation,
	input  wire logic [hsl2rgb_pkg::SL_W-1:0]  lightness,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [hsl2rgb_pkg::RGB_W-1:0] red,
	output logic      [hsl2rgb_pkg::RGB_W-1:0] green,
	output logic      [hsl2rgb_pkg::RGB_W-1:0] blue
);
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [FRAC_BITS-1:0] tr_s2, tg_s2, tb_s2;
	logic [FRAC_BITS:0]   p_s3, q_s3, span_s3;

	assign en        = !v_s5 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	hsl2rgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk        (clk),
		.en         (en),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness),
		.tr_s2      (tr_s2),
		.tg_s2      (tg_s2),
		.tb_s2      (tb_s2),
		.p_s3       (p_s3),
		.q_s3       (q_s3),
		.span_s3    (span_s3)
	);

	hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
		.clk     (clk),
		.en      (en),
		.t_s2    (tr_s2),
		.p_s3    (p_s3),
		.q_s3    (q_s3),
		.span_s3 (span_s3),
		.chan_s5 (red)
	);

	hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
		.clk     (clk),
		.en      (en),
		.t_s2    (tg_s2),
		.p_s3    (p_s3),
		.q_s3    (q_s3),
		.span_s3 (span_s3),
		.chan_s5 (green)
	);

	hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
		.clk     (clk),
		.en      (en),
		.t_s2    (tb_s2),
		.p_s3    (p_s3),
		.q_s3    (q_s3),
		.span_s3 (span_s3),
		.chan_s5 (blue)
	);

`ifndef SYNTHESIS
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s5 && !out_ready))
		else $error("input stalled without a blocked result");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted item did not enter stage 1");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s1) && $stable(v_s2) && $stable(v_s3) && $stable(v_s4)))
		else $error("pipeline moved during a stall");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s5) |-> $past(v_s4))
		else $error("result appeared without an item in stage 4");
`endif
endmodule
`default_nettype wire
